// ===== src/fsc_pkg.sv =====
// Shared types, constants and plane tables for the frustum sphere culling block.
// No dependencies; every other file imports this package.
`default_nettype none

package fsc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_COLS        = 4;
    localparam int ELEM_W          = 32;
    localparam int COL_W           = NUM_COLS * ELEM_W;
    localparam int NRM_W           = 18;

    // Stream widths: tdata holds the fields padded to whole bytes.
    localparam int S_TDATA_W = 264;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Iterative unit widths.
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int DVD_W      = 48;
    localparam int DVS_W      = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] LAST_COL = 2'd3;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUERY,
        ST_RB_READ,
        ST_RB_CAP,
        ST_RB_SQ,
        ST_RB_ACC,
        ST_RB_SQRT_GO,
        ST_RB_SQRT_WAIT,
        ST_RB_DIV_GO,
        ST_RB_DIV_WAIT,
        ST_RB_WRITE,
        ST_DONE
    } fsc_state_t;

    // Row combined with row w for each plane: left, right, top, bottom, front, back.
    function automatic logic [1:0] plane_row(input logic [2:0] p);
        logic [1:0] r;
        unique case (p)
            3'd0, 3'd1: r = 2'd0;
            3'd2, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    // 1 when the plane takes w plus the other row, 0 when it takes w minus it.
    function automatic logic plane_is_add(input logic [2:0] p);
        logic a;
        unique case (p)
            3'd0, 3'd3, 3'd4: a = 1'b1;
            default:          a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== src/fsc_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on fsc_pkg for widths and the status struct.
`default_nettype none

module fsc_isqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [fsc_pkg::SQ_W-1:0]  radicand,
    output logic      [fsc_pkg::ROOT_W-1:0] root,
    output fsc_pkg::unit_stat_t            stat
);
    import fsc_pkg::*;

    localparam int REM_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_W-1:0]   n_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_reg[REM_W-3:0], n_reg[SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            n_reg    <= {n_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== src/fsc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fsc_pkg for widths and the status struct.
`default_nettype none

module fsc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [fsc_pkg::DVD_W-1:0] dividend,
    input  wire logic [fsc_pkg::DVS_W-1:0] divisor,
    output logic      [fsc_pkg::DVD_W-1:0] quotient,
    output fsc_pkg::unit_stat_t            stat
);
    import fsc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] sh;
    logic [DVS_W:0] diff;
    logic           ge;

    assign sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff = sh - {1'b0, dvs_reg};
    assign ge   = sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== src/frustum_sphere_cull.sv =====
// Frustum sphere culling: one item is in work at a time; a new transfer is taken only once the
// previous result is in the output register. A query's six plane reads go back to back from
// the plane memory into a three-multiplier pipeline. Column 3 rebuilds each plane from a read
// of every column, a sum of squares, a square root, up to four divisions and one write, and is
// acknowledged when all six planes are written. Synchronous active-low reset.
`default_nettype none

module frustum_sphere_cull #(
    parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // col_index, elem_x, elem_y, elem_z, elem_w, pos_x, pos_y, pos_z, radius, zero pad
    input  wire logic [fsc_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic [fsc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // inside_res, zero pad
    output logic      [fsc_pkg::M_TDATA_W-1:0]  m_tdata,
    // is_query_result
    output logic      [fsc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import fsc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int EW    = (CW > NRM_W) ? CW : NRM_W;
    localparam int PROD_W = NRM_W + ELEM_W;
    localparam int ACC_W = PROD_W + 2;
    localparam int SH_W  = ACC_W - FRAC_BITS;
    localparam int DW    = ((CW > SH_W) ? CW : SH_W) + 2;
    localparam int ROW_W = NUM_COLS * CW;
    localparam int VW    = DVD_W + 1;
    localparam logic signed [VW-1:0] SAT_HI = (VW'(1) <<< (CW - 1)) - VW'(1);
    localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

    // Input fields.
    logic                     in_req;
    logic [1:0]               in_col;
    logic [COL_W-1:0]         in_column;
    logic signed [ELEM_W-1:0] in_pos_x, in_pos_y, in_pos_z;
    logic [30:0]              in_radius;

    assign in_req    = s_tuser[0];
    assign in_col    = s_tdata[1:0];
    assign in_column = s_tdata[129:2];
    assign in_pos_x  = s_tdata[161:130];
    assign in_pos_y  = s_tdata[193:162];
    assign in_pos_z  = s_tdata[225:194];
    assign in_radius = s_tdata[256:226];

    fsc_state_t state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Matrix memory: one column per entry, rows x, y, z, w from the low bits up.
    logic [COL_W-1:0]    mx_mem [NUM_COLS];
    logic [COL_W-1:0]    mx_rd_reg;
    logic                mx_ok_reg;
    logic [NUM_COLS-1:0] col_valid_reg;

    // Plane memory: one plane per entry, components x, y, z, d from the low bits up.
    logic [ROW_W-1:0] pl_mem [NUM_PLANES];
    logic [ROW_W-1:0] pl_rd_reg;
    logic             planes_ok_reg;

    // Item registers.
    logic signed [ELEM_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [30:0]              rad_reg;
    logic                     res_query_reg;
    logic                     inside_reg;

    // Rebuild datapath.
    logic [2:0]               p_reg;
    logic [1:0]               k_reg;
    logic signed [ELEM_W-1:0] raw_reg [NUM_COLS];
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sumsq_reg;
    logic [ROOT_W-1:0]        len_reg;
    logic signed [CW-1:0]     comp_reg [NUM_COLS];

    // Query pipeline.
    logic [2:0]               q_issue_reg;
    logic                     q_v1_reg, q_v2_reg, q_v3_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [CW-1:0]     d2_reg, d3_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Iterative units.
    logic              sqrt_start;
    logic [ROOT_W-1:0] sqrt_root;
    unit_stat_t        sqrt_stat;
    logic              div_start;
    logic [DVD_W-1:0]  div_quo;
    unit_stat_t        div_stat;
    logic [ELEM_W-1:0] raw_mag;
    logic              raw_neg;

    assign raw_neg = raw_reg[k_reg][ELEM_W-1];
    assign raw_mag = raw_neg ? (ELEM_W'(0) - raw_reg[k_reg]) : raw_reg[k_reg];

    fsc_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sumsq_reg),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    fsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({raw_mag, FRAC_BITS'(0)}),
        .divisor  (len_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign sqrt_start = (state_reg == ST_RB_SQRT_GO);
    assign div_start  = (state_reg == ST_RB_DIV_GO) && (len_reg != '0);

    // Raw plane component: w plus or minus the other row, saturated to 32 bits.
    logic [COL_W-1:0]         mx_col;
    logic signed [ELEM_W-1:0] row_w, row_o;
    logic signed [ELEM_W:0]   raw_sum;
    logic signed [ELEM_W-1:0] raw_sat;

    assign mx_col = mx_ok_reg ? mx_rd_reg : '0;
    assign row_w  = mx_col[3*ELEM_W +: ELEM_W];
    assign row_o  = mx_col[plane_row(p_reg)*ELEM_W +: ELEM_W];

    always_comb begin
        raw_sum = plane_is_add(p_reg) ? ((ELEM_W+1)'(row_w) + (ELEM_W+1)'(row_o))
                                      : ((ELEM_W+1)'(row_w) - (ELEM_W+1)'(row_o));
        if (raw_sum[ELEM_W] != raw_sum[ELEM_W-1]) begin
            raw_sat = raw_sum[ELEM_W] ? ELEM_MIN : ELEM_MAX;
        end else begin
            raw_sat = raw_sum[ELEM_W-1:0];
        end
    end

    // Signed, saturated quotient.
    logic signed [VW-1:0] q_signed;
    logic signed [CW-1:0] q_sat;

    always_comb begin
        q_signed = raw_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        if (q_signed > SAT_HI) begin
            q_sat = CW'(SAT_HI);
        end else if (q_signed < SAT_LO) begin
            q_sat = CW'(SAT_LO);
        end else begin
            q_sat = CW'(q_signed);
        end
    end

    // Query stage 1 operands. Normal components never exceed 1.0, so 18 bits carry them.
    logic [ROW_W-1:0]         pl_row;
    logic signed [NRM_W-1:0]  nrm [3];
    logic signed [EW-1:0]     nrm_ext [3];
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [DW-1:0]     sph_dist;
    logic signed [DW-1:0]     rad_ext;
    logic                     outside;

    assign pl_row = planes_ok_reg ? pl_rd_reg : '0;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nrm_ext[i] = EW'($signed(pl_row[i*CW +: CW]));
            nrm[i]     = nrm_ext[i][NRM_W-1:0];
        end
    end

    assign acc_sum  = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2]);
    assign rad_ext  = DW'(rad_reg);
    assign sph_dist = DW'(acc_reg >>> FRAC_BITS) + DW'(d3_reg) + rad_ext;
    assign outside  = sph_dist[DW-1] || (sph_dist == '0);

    // State register and next state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_req == REQ_QUERY) begin
                        state_next = ST_QUERY;
                    end else if (in_col == LAST_COL) begin
                        state_next = ST_RB_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_QUERY: begin
                if (q_issue_reg == 3'(NUM_PLANES) && !q_v1_reg && !q_v2_reg && !q_v3_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_RB_READ: state_next = ST_RB_CAP;
            ST_RB_CAP: state_next = (k_reg == LAST_COL) ? ST_RB_SQ : ST_RB_READ;
            ST_RB_SQ: state_next = ST_RB_ACC;
            ST_RB_ACC: state_next = (k_reg == 2'd2) ? ST_RB_SQRT_GO : ST_RB_SQ;
            ST_RB_SQRT_GO: state_next = ST_RB_SQRT_WAIT;
            ST_RB_SQRT_WAIT: begin
                if (sqrt_stat.done) begin
                    state_next = ST_RB_DIV_GO;
                end
            end
            ST_RB_DIV_GO: begin
                if (len_reg != '0) begin
                    state_next = ST_RB_DIV_WAIT;
                end else if (k_reg == LAST_COL) begin
                    state_next = ST_RB_WRITE;
                end
            end
            ST_RB_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = (k_reg == LAST_COL) ? ST_RB_WRITE : ST_RB_DIV_GO;
                end
            end
            ST_RB_WRITE: state_next = (p_reg == 3'(NUM_PLANES - 1)) ? ST_DONE : ST_RB_READ;
            ST_DONE: begin
                if (!m_tvalid || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_LOAD) begin
            mx_mem[in_col] <= in_column;
        end
        mx_rd_reg <= mx_mem[k_reg];
        mx_ok_reg <= col_valid_reg[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RB_WRITE) begin
            pl_mem[p_reg] <= {comp_reg[3], comp_reg[2], comp_reg[1], comp_reg[0]};
        end
        pl_rd_reg <= pl_mem[q_issue_reg];
    end

    // Control state cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_valid_reg <= '0;
            planes_ok_reg <= 1'b0;
            q_v1_reg      <= 1'b0;
            q_v2_reg      <= 1'b0;
            q_v3_reg      <= 1'b0;
            q_issue_reg   <= '0;
            m_tvalid      <= 1'b0;
        end else begin
            if (accept && in_req == REQ_LOAD) begin
                col_valid_reg[in_col] <= 1'b1;
            end
            if (state_reg == ST_RB_WRITE && p_reg == 3'(NUM_PLANES - 1)) begin
                planes_ok_reg <= 1'b1;
            end
            if (accept) begin
                q_issue_reg <= '0;
            end else if (state_reg == ST_QUERY && q_issue_reg != 3'(NUM_PLANES)) begin
                q_issue_reg <= q_issue_reg + 1'b1;
            end
            q_v1_reg <= (state_reg == ST_QUERY) && (q_issue_reg != 3'(NUM_PLANES));
            q_v2_reg <= q_v1_reg;
            q_v3_reg <= q_v2_reg;
            if (state_reg == ST_DONE && (!m_tvalid || m_tready)) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_x_reg     <= in_pos_x;
            pos_y_reg     <= in_pos_y;
            pos_z_reg     <= in_pos_z;
            rad_reg       <= in_radius;
            res_query_reg <= in_req;
            inside_reg    <= in_req;
            p_reg         <= '0;
            k_reg         <= '0;
        end

        if (q_v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PROD_W'(nrm[i]) * PROD_W'(i == 0 ? pos_x_reg :
                                                         i == 1 ? pos_y_reg : pos_z_reg);
            end
            d2_reg <= $signed(pl_row[3*CW +: CW]);
        end
        if (q_v2_reg) begin
            acc_reg <= acc_sum;
            d3_reg  <= d2_reg;
        end
        if (q_v3_reg && outside) begin
            inside_reg <= 1'b0;
        end

        unique case (state_reg)
            ST_RB_CAP: begin
                raw_reg[k_reg] <= raw_sat;
                if (k_reg == LAST_COL) begin
                    sumsq_reg <= '0;
                end
                k_reg <= k_reg + 1'b1;
            end
            ST_RB_SQ: begin
                sq_reg <= SQ_W'(raw_reg[k_reg] * raw_reg[k_reg]);
            end
            ST_RB_ACC: begin
                sumsq_reg <= sumsq_reg + sq_reg;
                k_reg     <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
            end
            ST_RB_SQRT_WAIT: begin
                if (sqrt_stat.done) begin
                    len_reg <= sqrt_root;
                end
            end
            ST_RB_DIV_GO: begin
                // A zero-length normal stores the whole plane as zero.
                if (len_reg == '0) begin
                    comp_reg[k_reg] <= '0;
                    k_reg           <= k_reg + 1'b1;
                end
            end
            ST_RB_DIV_WAIT: begin
                if (div_stat.done) begin
                    comp_reg[k_reg] <= q_sat;
                    k_reg           <= k_reg + 1'b1;
                end
            end
            ST_RB_WRITE: begin
                p_reg <= p_reg + 1'b1;
                k_reg <= '0;
            end
            default: begin
            end
        endcase

        if (state_reg == ST_DONE && (!m_tvalid || m_tready)) begin
            m_tuser <= M_TUSER_W'(res_query_reg);
            m_tdata <= M_TDATA_W'(inside_reg);
        end
    end

endmodule

`default_nettype wire

// ===== src/fsc_checker.sv =====
// Port-level checks for frustum_sphere_cull, bound to the top level.
// Depends only on fsc_pkg widths and the top level's ports.
`default_nettype none

module fsc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [fsc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [fsc_pkg::M_TUSER_W-1:0] m_tuser
);
    import fsc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("load acknowledge carries a nonzero verdict");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while an item is in work");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind frustum_sphere_cull fsc_checker u_fsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for frustum_sphere_cull: plane loads and sphere queries.
// Depends on fsc_pkg and the frustum_sphere_cull RTL; predicts every result internally.
`default_nettype none

class cull_scoreboard;
    logic signed [63:0] mat [16];
    logic signed [63:0] pln [24];
    bit exp_q [$];
    bit exp_in [$];
    int mismatches;
    int checked;

    function void clear();
        foreach (mat[i]) mat[i] = 0;
        foreach (pln[i]) pln[i] = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void rebuild_planes();
        int orow [6];
        int add [6];
        logic signed [63:0] raw [4];
        logic signed [63:0] s, val;
        logic [63:0] sumsq, len, mag, q;
        orow = '{0, 0, 1, 1, 2, 2};
        add = '{1, 0, 0, 1, 1, 0};
        for (int p = 0; p < 6; p++) begin
            sumsq = 0;
            for (int k = 0; k < 4; k++) begin
                s = add[p] ? mat[k*4+3] + mat[k*4+orow[p]] : mat[k*4+3] - mat[k*4+orow[p]];
                if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
                if (s < -64'sh8000_0000) s = -64'sh8000_0000;
                raw[k] = s;
            end
            for (int k = 0; k < 3; k++) sumsq = sumsq + raw[k] * raw[k];
            len = int_sqrt(sumsq);
            for (int k = 0; k < 4; k++) begin
                val = 0;
                if (len != 0) begin
                    mag = raw[k] < 0 ? -raw[k] : raw[k];
                    q = (mag << 16) / len;
                    val = raw[k] < 0 ? -$signed(q) : $signed(q);
                end
                if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
                if (val < -64'sh8000_0000) val = -64'sh8000_0000;
                pln[p*4+k] = val;
            end
        end
    endfunction

    // Notes one accepted input transfer and queues the result it must cause.
    function void note_input(input logic req, input logic [1:0] col,
                             input logic [31:0] e [4], input logic [31:0] pos [3],
                             input logic [30:0] rad);
        logic signed [127:0] acc;
        logic signed [127:0] dist_v;
        bit vis;
        if (req == fsc_pkg::REQ_LOAD) begin
            for (int r = 0; r < 4; r++) mat[col*4+r] = $signed(e[r]);
            if (col == fsc_pkg::LAST_COL) rebuild_planes();
            exp_q.push_back(0);
            exp_in.push_back(0);
        end else begin
            vis = 1;
            for (int p = 0; p < 6; p++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = acc + 128'(pln[p*4+k]) * 128'($signed(pos[k]));
                dist_v = (acc >>> 16) + 128'(pln[p*4+3]) + $signed({97'd0, rad});
                if (dist_v <= 0) vis = 0;
            end
            exp_q.push_back(1);
            exp_in.push_back(vis);
        end
    endfunction

    function void check_result(input logic q, input logic ins);
        bit eq, ei;
        if (exp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with nothing expected: q=%0d in=%0d", q, ins);
            return;
        end
        eq = exp_q.pop_front();
        ei = exp_in.pop_front();
        checked++;
        if (q !== eq || ins !== ei) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch #%0d: expected q=%0d in=%0d, got q=%0d in=%0d",
                         checked, eq, ei, q, ins);
        end
    endfunction
endclass

module tb;
    import fsc_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    cull_scoreboard sb;
    int idle_cycles;
    bit no_idle;
    bit hold_off;
    int n_loads, n_queries, n_rebuilds;

    frustum_sphere_cull dut (.*);

    always #5 aclk = ~aclk;

    // Interesting 32-bit values for matrix and position entries.
    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            4: return 32'd0;
            5, 6: return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [30:0] pick_rad();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0004_0000));
        endcase
    endfunction

    task automatic send(input logic req, input logic [1:0] col,
                        input logic [31:0] e [4], input logic [31:0] pos [3],
                        input logic [30:0] rad);
        while (!no_idle && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {7'd0, rad, pos[2], pos[1], pos[0], e[3], e[2], e[1], e[0], col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(req, col, e, pos, rad);
        if (req == REQ_LOAD) begin
            n_loads++;
            if (col == LAST_COL) n_rebuilds++;
        end else begin
            n_queries++;
        end
        @(negedge aclk);
    endtask

    task automatic load_col(input logic [1:0] col, input logic [31:0] e [4]);
        logic [31:0] pz [3];
        pz = '{$urandom, $urandom, $urandom};
        send(REQ_LOAD, col, e, pz, 31'($urandom));
    endtask

    task automatic query(input logic [31:0] pos [3], input logic [30:0] rad);
        logic [31:0] ez [4];
        ez = '{$urandom, $urandom, $urandom, $urandom};
        send(REQ_QUERY, 2'($urandom), ez, pos, rad);
    endtask

    task automatic load_matrix(input bit ident);
        logic [31:0] e [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++)
                e[r] = ident ? ((r == c) ? 32'h0001_0000 : 32'd0) : pick_val();
            load_col(2'(c), e);
        end
    endtask

    task automatic random_query();
        logic [31:0] p [3];
        p = '{pick_val(), pick_val(), pick_val()};
        query(p, pick_rad());
    endtask

    // Receiver side: random stalls, plus one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 0;
        else m_tready <= no_idle || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata[0]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] e [4];
        logic [31:0] p [3];
        sb = new();
        sb.clear();
        idle_cycles = 0;
        hold_off = 0;
        no_idle = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Queries before any rebuild: only a zero radius is rejected.
        p = '{32'd0, 32'd0, 32'd0};
        query(p, 31'd0);
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        query(p, 31'h7FFF_FFFF);
        query(p, 31'd1);
        // A partial load leaves the planes at zero.
        e = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
        load_col(2'd0, e);
        query(p, 31'd0);
        // Identity matrix gives the unit cube.
        load_matrix(1);
        p = '{32'd0, 32'd0, 32'd0};
        query(p, 31'd0);
        p = '{32'h0003_0000, 32'd0, 32'd0};
        query(p, 31'h0001_0000);
        query(p, 31'h0002_0000);
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        query(p, 31'h7FFF_FFFF);
        // Saturating sums in every column.
        for (int c = 0; c < 4; c++) begin
            e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
            load_col(2'(c), e);
        end
        query(p, 31'd5);
        // All-zero matrix: zero-length normals everywhere.
        e = '{32'd0, 32'd0, 32'd0, 32'd0};
        for (int c = 0; c < 4; c++) load_col(2'(c), e);
        query(p, 31'd0);
        query(p, 31'd1);

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            repeat (8) random_query();
        join

        // Random: mostly a matrix followed by a run of queries.
        while (n_loads + n_queries < 1850) begin
            no_idle = (n_loads + n_queries > 1000 && n_loads + n_queries < 1200);
            if ($urandom_range(0, 19) == 0) begin
                for (int r = 0; r < 4; r++) e[r] = pick_val();
                load_col(2'($urandom_range(0, 2)), e);
            end else if ($urandom_range(0, 24) == 0) begin
                load_matrix($urandom_range(0, 3) == 0);
            end else begin
                random_query();
            end
        end
        no_idle = 0;
        s_tvalid <= 0;

        while (sb.exp_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d loads (%0d plane rebuilds) and %0d sphere queries, %0d checked",
                 n_loads, n_rebuilds, n_queries, sb.checked);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== frustum_sphere_cull.f =====
src/fsc_pkg.sv
src/fsc_isqrt.sv
src/fsc_div.sv
src/frustum_sphere_cull.sv
src/fsc_checker.sv
tb/tb.sv
